>>> hw/rtl/assv_pkg.sv
// Shared types and codes for the autonomous system state supervisor.
`timescale 1ns / 1ps

package assv_pkg;

  // system_state codes
  localparam logic [2:0] ST_OFF       = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_DRIVING   = 3'd2;
  localparam logic [2:0] ST_EMERGENCY = 3'd3;
  localparam logic [2:0] ST_FINISHED  = 3'd4;

  // mission_status code for a finished mission
  localparam logic [1:0] MS_FINISHED = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_ENGINE_RPM       = 3'd0;
  localparam logic [2:0] CFG_MIN_BRAKE_PRESSURE   = 3'd1;
  localparam logic [2:0] CFG_BRAKE_SYSTEM_CHECKED = 3'd2;
  localparam logic [2:0] CFG_READY_WAIT_MS        = 3'd3;
  localparam logic [2:0] CFG_SIREN_TIME_MS        = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] RST_MIN_ENGINE_RPM     = 16'd500;
  localparam logic [7:0]  RST_MIN_BRAKE_PRESSURE = 8'd10;
  localparam logic        RST_BRAKE_CHECKED      = 1'b1;
  localparam logic [15:0] RST_READY_WAIT_MS      = 16'd5000;
  localparam logic [15:0] RST_SIREN_TIME_MS      = 16'd9000;

  typedef struct packed {
    logic [15:0] min_engine_rpm;
    logic [7:0]  min_brake_pressure;
    logic        brake_system_checked;
    logic [15:0] ready_wait_ms;
    logic [15:0] siren_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        shutdown_closed;
    logic [1:0]  mission_status;
    logic [2:0]  mission_select;
    logic        master_switch_on;
    logic [15:0] engine_rpm;
    logic [7:0]  brake_pressure;
    logic        gear_neutral;
    logic        remote_go;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] system_state;
    logic       yellow_lamp;
    logic       blue_lamp;
    logic       siren_on;
    logic       send_go;
  } res_t;

  typedef struct packed {
    logic        ready_armed;
    logic [31:0] ready_start;
    logic        emergency_armed;
    logic [31:0] emergency_start;
    logic        yellow_level;
    logic        blue_level;
  } sup_t;

endpackage

>>> hw/rtl/assv_cfg.sv
// Configuration register file for the supervisor thresholds and timers.
`timescale 1ns / 1ps

module assv_cfg
  import assv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_engine_rpm       <= RST_MIN_ENGINE_RPM;
      cfg_r.min_brake_pressure   <= RST_MIN_BRAKE_PRESSURE;
      cfg_r.brake_system_checked <= RST_BRAKE_CHECKED;
      cfg_r.ready_wait_ms        <= RST_READY_WAIT_MS;
      cfg_r.siren_time_ms        <= RST_SIREN_TIME_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ENGINE_RPM:       cfg_r.min_engine_rpm       <= cfg_wdata;
        CFG_MIN_BRAKE_PRESSURE:   cfg_r.min_brake_pressure   <= cfg_wdata[7:0];
        CFG_BRAKE_SYSTEM_CHECKED: cfg_r.brake_system_checked <= cfg_wdata[0];
        CFG_READY_WAIT_MS:        cfg_r.ready_wait_ms        <= cfg_wdata;
        CFG_SIREN_TIME_MS:        cfg_r.siren_time_ms        <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/assv_eval.sv
// State decision, lamp, siren and go logic for one evaluation word.
`timescale 1ns / 1ps

module assv_eval
  import assv_pkg::*;
(
  input  item_t item,
  input  cfg_t  cfg,
  input  sup_t  sup,
  output res_t  res,
  output sup_t  sup_nxt
);

  logic [2:0]  st;
  logic        run_ok;
  logic [31:0] rdy_start;
  logic [31:0] emg_start;
  logic [31:0] rdy_elapsed;
  logic [31:0] emg_elapsed;

  assign run_ok = (item.mission_select != 3'd0) && item.master_switch_on &&
                  cfg.brake_system_checked && (item.engine_rpm >= cfg.min_engine_rpm);

  always_comb begin
    if (!item.shutdown_closed) begin
      st = (item.mission_status == MS_FINISHED) ? ST_FINISHED : ST_EMERGENCY;
    end else if (run_ok) begin
      if (!item.gear_neutral) begin
        st = ST_DRIVING;
      end else if (item.brake_pressure >= cfg.min_brake_pressure) begin
        st = ST_READY;
      end else begin
        st = ST_OFF;
      end
    end else begin
      st = ST_OFF;
    end
  end

  // start time as seen on this word: latched now on first entry
  assign rdy_start   = sup.ready_armed ? item.now_ms : sup.ready_start;
  assign emg_start   = sup.emergency_armed ? item.now_ms : sup.emergency_start;
  assign rdy_elapsed = item.now_ms - rdy_start;
  assign emg_elapsed = item.now_ms - emg_start;

  always_comb begin
    sup_nxt          = sup;
    res.system_state = st;
    res.siren_on     = 1'b0;
    res.send_go      = 1'b0;
    case (st)
      ST_FINISHED: begin
        sup_nxt.yellow_level = 1'b0;
        sup_nxt.blue_level   = 1'b1;
      end
      ST_EMERGENCY: begin
        sup_nxt.blue_level      = ~sup.blue_level;
        sup_nxt.yellow_level    = 1'b0;
        sup_nxt.emergency_start = emg_start;
        sup_nxt.emergency_armed = 1'b0;
        res.siren_on = (emg_elapsed < {16'd0, cfg.siren_time_ms});
      end
      ST_DRIVING: begin
        sup_nxt.blue_level   = 1'b0;
        sup_nxt.yellow_level = ~sup.yellow_level;
      end
      ST_READY: begin
        sup_nxt.ready_start  = rdy_start;
        sup_nxt.ready_armed  = 1'b0;
        sup_nxt.yellow_level = 1'b1;
        sup_nxt.blue_level   = 1'b0;
        res.send_go = item.remote_go && (rdy_elapsed > {16'd0, cfg.ready_wait_ms});
      end
      default: begin
        sup_nxt.yellow_level    = 1'b0;
        sup_nxt.blue_level      = 1'b0;
        sup_nxt.ready_armed     = 1'b1;
        sup_nxt.emergency_armed = 1'b1;
      end
    endcase
    res.yellow_lamp = sup_nxt.yellow_level;
    res.blue_lamp   = sup_nxt.blue_level;
  end

endmodule

>>> hw/rtl/autonomous_system_state_supervisor.sv
// Top level of the autonomous system state supervisor.
// A word passes the input register, one evaluation pass and the result register.
// Throughput: one word per cycle unless out_stall holds a full result register.
// in_stall rises only when the input register is full and the result register is held.
// Reset (rst_n low, synchronous): both valids cleared, latches armed, lamps off,
// configuration back to its defaults.
`timescale 1ns / 1ps

module autonomous_system_state_supervisor
  import assv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_shutdown_closed,
  input  logic [1:0]            in_mission_status,
  input  logic [2:0]            in_mission_select,
  input  logic                  in_master_switch_on,
  input  logic [15:0]           in_engine_rpm,
  input  logic [7:0]            in_brake_pressure,
  input  logic                  in_gear_neutral,
  input  logic                  in_remote_go,
  input  logic [31:0]           in_now_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_system_state,
  output logic                  out_yellow_lamp,
  output logic                  out_blue_lamp,
  output logic                  out_siren_on,
  output logic                  out_send_go,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  res_t  res_nxt;
  res_t  out_res_r;
  logic  out_valid_r;
  sup_t  sup_r;
  sup_t  sup_nxt;
  logic  advance;
  logic  eval_fire;

  // Result register can take a new word when empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  // Supervisor state moves exactly once per evaluated word, in arrival order.
  assign eval_fire = s1_valid_r && advance;

  assv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.shutdown_closed  <= in_shutdown_closed;
      s1_item_r.mission_status   <= in_mission_status;
      s1_item_r.mission_select   <= in_mission_select;
      s1_item_r.master_switch_on <= in_master_switch_on;
      s1_item_r.engine_rpm       <= in_engine_rpm;
      s1_item_r.brake_pressure   <= in_brake_pressure;
      s1_item_r.gear_neutral     <= in_gear_neutral;
      s1_item_r.remote_go        <= in_remote_go;
      s1_item_r.now_ms           <= in_now_ms;
    end
  end

  assv_eval u_eval (
    .item    (s1_item_r),
    .cfg     (cfg),
    .sup     (sup_r),
    .res     (res_nxt),
    .sup_nxt (sup_nxt)
  );

  // Supervisor state: start latches and lamp toggle levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r.ready_armed     <= 1'b1;
      sup_r.ready_start     <= 32'd0;
      sup_r.emergency_armed <= 1'b1;
      sup_r.emergency_start <= 32'd0;
      sup_r.yellow_level    <= 1'b0;
      sup_r.blue_level      <= 1'b0;
    end else if (eval_fire) begin
      sup_r <= sup_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_system_state = out_res_r.system_state;
  assign out_yellow_lamp  = out_res_r.yellow_lamp;
  assign out_blue_lamp    = out_res_r.blue_lamp;
  assign out_siren_on     = out_res_r.siren_on;
  assign out_send_go      = out_res_r.send_go;

endmodule

>>> hw/rtl/assv_chk.sv
// Port-level checker for the supervisor, bound to the top level.
`timescale 1ns / 1ps

module assv_chk
  import assv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            out_system_state,
  input logic                  out_yellow_lamp,
  input logic                  out_blue_lamp,
  input logic                  out_siren_on,
  input logic                  out_send_go
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_system_state) &&
      $stable(out_yellow_lamp) && $stable(out_blue_lamp) &&
      $stable(out_siren_on) && $stable(out_send_go))
    else $error("stalled result word changed");

  a_go_ready_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_go |-> out_system_state == ST_READY)
    else $error("go issued outside ready");

  a_ready_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_system_state == ST_READY |-> out_yellow_lamp && !out_blue_lamp)
    else $error("wrong lamps in ready");

  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_system_state == ST_OFF |->
      !out_yellow_lamp && !out_blue_lamp && !out_siren_on)
    else $error("lamps or siren active in off");

  a_siren_emg_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_siren_on |-> out_system_state == ST_EMERGENCY)
    else $error("siren outside emergency");

endmodule

bind autonomous_system_state_supervisor assv_chk u_assv_chk (.*);
